// ===== rtl/lbu_pkg.sv =====
// ----------------------------------------------------------------------------
// lbu_pkg: shared types and constants for the letterbox box unmap block
// Field widths, register indexes, category codes, pipeline depths and the
// result record carried to the output buffer.
// ----------------------------------------------------------------------------
package lbu_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_RATIO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // Field widths
    localparam int EDGE_W  = 16;
    localparam int PAD_W   = 12;
    localparam int RATIO_W = 18;
    localparam int SIZE_W  = 14;
    localparam int CLASS_W = 8;
    localparam int SCORE_W = 16;
    localparam int NORM_W  = 17;
    localparam int CAT_W   = 14;

    // Corner in original pixels, unsigned Q.16, never above size << 16
    localparam int COORD_W = SIZE_W + 16;

    // Reset values
    localparam logic [PAD_W-1:0]   PAD_RESET   = '0;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 18'd65536;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 14'd640;

    // Category codes and Q1.16 one
    localparam logic [CAT_W-1:0]  CODE_WORN  = 14'd10001;
    localparam logic [CAT_W-1:0]  CODE_OTHER = 14'd10002;
    localparam logic [NORM_W-1:0] ONE_Q16    = 17'd65536;

    // Pipeline depths
    localparam int CDIV_STEPS = COORD_W;          // one quotient bit per stage
    localparam int NDIV_STEPS = NORM_W;
    localparam int CORNER_LAT = CDIV_STEPS + 2;   // prep, steps, clip
    localparam int NORM_LAT   = NDIV_STEPS + 1;   // load, steps
    localparam int PIPE_LAT   = CORNER_LAT + NORM_LAT;

    typedef struct packed {
        logic [NORM_W-1:0]  norm_x;
        logic [NORM_W-1:0]  norm_y;
        logic [NORM_W-1:0]  norm_w;
        logic [NORM_W-1:0]  norm_h;
        logic [CAT_W-1:0]   category;
        logic [SCORE_W-1:0] confidence;
    } res_t;

endpackage

// ===== rtl/lbu_if.sv =====
// ----------------------------------------------------------------------------
// lbu_if: request channels of the letterbox box unmap block
// Box request, result request and configuration write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface lbu_box_if
    import lbu_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [EDGE_W-1:0]  left_edge;
    logic signed [EDGE_W-1:0]  top_edge;
    logic signed [EDGE_W-1:0]  right_edge;
    logic signed [EDGE_W-1:0]  bottom_edge;
    logic [CLASS_W-1:0]        class_index;
    logic [SCORE_W-1:0]        score_in;

    modport source (
        output valid, left_edge, top_edge, right_edge, bottom_edge,
               class_index, score_in,
        input  ready
    );
    modport sink (
        input  valid, left_edge, top_edge, right_edge, bottom_edge,
               class_index, score_in,
        output ready
    );
endinterface

interface lbu_res_if
    import lbu_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [NORM_W-1:0]  norm_x;
    logic [NORM_W-1:0]  norm_y;
    logic [NORM_W-1:0]  norm_w;
    logic [NORM_W-1:0]  norm_h;
    logic [CAT_W-1:0]   category;
    logic [SCORE_W-1:0] confidence;

    modport source (
        output valid, norm_x, norm_y, norm_w, norm_h, category, confidence,
        input  ready
    );
    modport sink (
        input  valid, norm_x, norm_y, norm_w, norm_h, category, confidence,
        output ready
    );
endinterface

interface lbu_cfg_if
    import lbu_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/lbu_corner_div.sv =====
// ----------------------------------------------------------------------------
// lbu_corner_div: one box corner from model pixels to original pixels
// Removes padding, divides by the scale ratio one quotient bit per stage
// (restoring), and clips the result to [0, size << 16].
// ----------------------------------------------------------------------------
module lbu_corner_div
    import lbu_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [EDGE_W-1:0] edge_in,
    input  logic [PAD_W-1:0]         pad,
    input  logic [RATIO_W-1:0]       ratio,
    input  logic [SIZE_W-1:0]        size,
    output logic [COORD_W-1:0]       coord
);

    logic [RATIO_W-1:0]  unpad;
    logic                positive;
    logic                sat;
    logic [COORD_W-1:0]  limit;

    logic [RATIO_W-1:0]  rem_reg  [0:CDIV_STEPS];
    logic [1:0]          feed_reg [0:CDIV_STEPS];
    logic [COORD_W-1:0]  quo_reg  [0:CDIV_STEPS];
    logic                zero_reg [0:CDIV_STEPS];
    logic                sat_reg  [0:CDIV_STEPS];
    logic [RATIO_W:0]    shifted  [1:CDIV_STEPS];
    logic [RATIO_W:0]    trial    [1:CDIV_STEPS];
    logic [COORD_W-1:0]  coord_reg;

    // Corner less padding, Q.4, modulo 2^18 (range fits signed 18 bits)
    assign unpad = {{(RATIO_W-EDGE_W){edge_in[EDGE_W-1]}}, edge_in}
                 - {2'b00, pad, 4'b0000};
    assign positive = !unpad[RATIO_W-1] && (unpad != '0);
    // Quotient reaches 2^30 (past any clip limit) when unpad >= 4 * ratio
    assign sat = {5'b00000, unpad[14:0]} >= {ratio, 2'b00};
    assign limit = {size, 16'h0000};

    always_comb
    begin
        for (int s = 1; s <= CDIV_STEPS; s++)
        begin
            shifted[s] = {rem_reg[s-1], feed_reg[s-1][1]};
            trial[s]   = shifted[s] - {1'b0, ratio};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Load: bits above the quotient window form the first remainder
            rem_reg[0]  <= {5'b00000, unpad[14:2]};
            feed_reg[0] <= unpad[1:0];
            quo_reg[0]  <= '0;
            zero_reg[0] <= !positive;
            sat_reg[0]  <= sat;
            for (int s = 1; s <= CDIV_STEPS; s++)
            begin
                rem_reg[s]  <= trial[s][RATIO_W] ? shifted[s][RATIO_W-1:0]
                                                 : trial[s][RATIO_W-1:0];
                quo_reg[s]  <= {quo_reg[s-1][COORD_W-2:0], !trial[s][RATIO_W]};
                feed_reg[s] <= {feed_reg[s-1][0], 1'b0};
                zero_reg[s] <= zero_reg[s-1];
                sat_reg[s]  <= sat_reg[s-1];
            end
            // Clip to the image
            if (zero_reg[CDIV_STEPS])
                coord_reg <= '0;
            else if (sat_reg[CDIV_STEPS] || (quo_reg[CDIV_STEPS] > limit))
                coord_reg <= limit;
            else
                coord_reg <= quo_reg[CDIV_STEPS];
        end
    end

    assign coord = coord_reg;

endmodule

// ===== rtl/lbu_norm_div.sv =====
// ----------------------------------------------------------------------------
// lbu_norm_div: Q.16 pixel value over image size into a Q1.16 fraction
// Restoring division, one quotient bit per stage; the dividend never
// exceeds size << 16, so the quotient fits 17 bits.
// ----------------------------------------------------------------------------
module lbu_norm_div
    import lbu_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [COORD_W-1:0]  dividend,
    input  logic [SIZE_W-1:0]   divisor,
    output logic [NORM_W-1:0]   quotient
);

    logic [SIZE_W-1:0] rem_reg  [0:NDIV_STEPS];
    logic [NORM_W-1:0] feed_reg [0:NDIV_STEPS];
    logic [NORM_W-1:0] quo_reg  [0:NDIV_STEPS];
    logic [SIZE_W:0]   shifted  [1:NDIV_STEPS];
    logic [SIZE_W:0]   trial    [1:NDIV_STEPS];

    always_comb
    begin
        for (int s = 1; s <= NDIV_STEPS; s++)
        begin
            shifted[s] = {rem_reg[s-1], feed_reg[s-1][NORM_W-1]};
            trial[s]   = shifted[s] - {1'b0, divisor};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {1'b0, dividend[COORD_W-1:NORM_W]};
            feed_reg[0] <= dividend[NORM_W-1:0];
            quo_reg[0]  <= '0;
            for (int s = 1; s <= NDIV_STEPS; s++)
            begin
                rem_reg[s]  <= trial[s][SIZE_W] ? shifted[s][SIZE_W-1:0]
                                                : trial[s][SIZE_W-1:0];
                quo_reg[s]  <= {quo_reg[s-1][NORM_W-2:0], !trial[s][SIZE_W]};
                feed_reg[s] <= {feed_reg[s-1][NORM_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg[NDIV_STEPS];

endmodule

// ===== rtl/letterbox_box_unmap_top.sv =====
// ----------------------------------------------------------------------------
// letterbox_box_unmap_top: detection box from letterboxed to image fractions
// Takes one box per cycle while the skid buffer is empty and returns its
// normalized x, y, width and height (Q1.16), a category code and the score.
// The arithmetic is two chains of restoring dividers, one quotient bit per
// stage: 30 stages for the divide by the scale ratio, 17 for the divide by
// the image size, plus load and clip stages. Results leave in request
// order through an output register backed by a one-entry skid buffer, so
// the box channel keeps flowing while a finished result waits; ready drops
// only when both are full. Configuration writes are taken at any time
// (ready is always high) but must land only while no box is in flight.
// A scale ratio or image size written as zero is stored as a raw 1.
// ----------------------------------------------------------------------------
module letterbox_box_unmap_top
    import lbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lbu_cfg_if.sink   cfg,
    lbu_box_if.sink   box,
    lbu_res_if.source res
);

    // ------------------------------------------------------------------
    // Configuration registers; zero ratio and zero sizes stored as raw one
    // ------------------------------------------------------------------
    logic [PAD_W-1:0]   pad_left_reg;
    logic [PAD_W-1:0]   pad_top_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;

    logic [RATIO_W-1:0] ratio_next;
    logic [SIZE_W-1:0]  size_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        ratio_next = (cfg.data[RATIO_W-1:0] == '0) ? RATIO_W'(1)
                                                   : cfg.data[RATIO_W-1:0];
        size_next  = (cfg.data[SIZE_W-1:0] == '0) ? SIZE_W'(1)
                                                  : cfg.data[SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_left_reg <= PAD_RESET;
            pad_top_reg  <= PAD_RESET;
            ratio_reg    <= RATIO_RESET;
            width_reg    <= SIZE_RESET;
            height_reg   <= SIZE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PAD_LEFT:     pad_left_reg <= cfg.data[PAD_W-1:0];
                REG_PAD_TOP:      pad_top_reg  <= cfg.data[PAD_W-1:0];
                REG_SCALE_RATIO:  ratio_reg    <= ratio_next;
                REG_IMAGE_WIDTH:  width_reg    <= size_next;
                REG_IMAGE_HEIGHT: height_reg   <= size_next;
                default:          ;  // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the skid
    // buffer holds a result
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;

    assign en        = !skid_valid_reg;
    assign box.ready = en;

    // Valid bits and pass-through fields travel alongside the arithmetic
    logic [PIPE_LAT-1:0] valid_reg;
    logic                worn_reg  [0:PIPE_LAT-1];
    logic [SCORE_W-1:0]  score_reg [0:PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[PIPE_LAT-2:0], box.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            worn_reg[0]  <= (box.class_index == '0);
            score_reg[0] <= box.score_in;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                worn_reg[i]  <= worn_reg[i-1];
                score_reg[i] <= score_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Corners: strip padding, divide by scale ratio, clip to the image
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;

    lbu_corner_div u_left (
        .clk     (clk),
        .en      (en),
        .edge_in (box.left_edge),
        .pad     (pad_left_reg),
        .ratio   (ratio_reg),
        .size    (width_reg),
        .coord   (x1)
    );

    lbu_corner_div u_top (
        .clk     (clk),
        .en      (en),
        .edge_in (box.top_edge),
        .pad     (pad_top_reg),
        .ratio   (ratio_reg),
        .size    (height_reg),
        .coord   (y1)
    );

    lbu_corner_div u_right (
        .clk     (clk),
        .en      (en),
        .edge_in (box.right_edge),
        .pad     (pad_left_reg),
        .ratio   (ratio_reg),
        .size    (width_reg),
        .coord   (x2)
    );

    lbu_corner_div u_bottom (
        .clk     (clk),
        .en      (en),
        .edge_in (box.bottom_edge),
        .pad     (pad_top_reg),
        .ratio   (ratio_reg),
        .size    (height_reg),
        .coord   (y2)
    );

    // Size in pixels: reversed corners give zero
    logic [COORD_W-1:0] wp;
    logic [COORD_W-1:0] hp;

    assign wp = (x2 > x1) ? (x2 - x1) : '0;
    assign hp = (y2 > y1) ? (y2 - y1) : '0;

    // ------------------------------------------------------------------
    // Normalize by image size
    // ------------------------------------------------------------------
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic [NORM_W-1:0] nw;
    logic [NORM_W-1:0] nh;

    lbu_norm_div u_norm_x (
        .clk      (clk),
        .en       (en),
        .dividend (x1),
        .divisor  (width_reg),
        .quotient (nx)
    );

    lbu_norm_div u_norm_y (
        .clk      (clk),
        .en       (en),
        .dividend (y1),
        .divisor  (height_reg),
        .quotient (ny)
    );

    lbu_norm_div u_norm_w (
        .clk      (clk),
        .en       (en),
        .dividend (wp),
        .divisor  (width_reg),
        .quotient (nw)
    );

    lbu_norm_div u_norm_h (
        .clk      (clk),
        .en       (en),
        .dividend (hp),
        .divisor  (height_reg),
        .quotient (nh)
    );

    // ------------------------------------------------------------------
    // Final clamp: position never exceeds one since the corner was clipped
    // to the image; size is held within what is left past the position
    // ------------------------------------------------------------------
    res_t              result_next;
    logic [NORM_W-1:0] room_x;
    logic [NORM_W-1:0] room_y;

    always_comb
    begin
        room_x = ONE_Q16 - nx;
        room_y = ONE_Q16 - ny;
        result_next.norm_x     = nx;
        result_next.norm_y     = ny;
        result_next.norm_w     = (nw > room_x) ? room_x : nw;
        result_next.norm_h     = (nh > room_y) ? room_y : nh;
        result_next.category   = worn_reg[PIPE_LAT-1] ? CODE_WORN : CODE_OTHER;
        result_next.confidence = score_reg[PIPE_LAT-1];
    end

    // ------------------------------------------------------------------
    // Output register with skid buffer
    // ------------------------------------------------------------------
    logic last_valid;
    logic out_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    assign last_valid = valid_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || res.ready)
        begin
            // Output slot frees up: refill from skid first, then the pipe
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= en && last_valid;
        end
        else if (en && last_valid)
            skid_valid_reg <= 1'b1;  // hold the arriving result aside
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || res.ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (en && last_valid)
                out_reg <= result_next;
        end
        else if (en && last_valid)
            skid_reg <= result_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.norm_x     = out_reg.norm_x;
    assign res.norm_y     = out_reg.norm_y;
    assign res.norm_w     = out_reg.norm_w;
    assign res.norm_h     = out_reg.norm_h;
    assign res.category   = out_reg.category;
    assign res.confidence = out_reg.confidence;

endmodule
